// ----- src/fgsm_pkg.sv -----
// Shared types, constants and functions for the filename glob and substring matcher.
package fgsm_pkg;

    // Pattern geometry.
    localparam int C_PAT_BYTES = 32;
    localparam int C_ACT_W     = C_PAT_BYTES + 1;
    localparam int C_LEN_W     = $clog2(C_PAT_BYTES + 1);
    localparam int C_WORD_W    = 64;
    localparam int C_WORD_BYTES = C_WORD_W / 8;
    localparam int C_WORDS     = C_PAT_BYTES / C_WORD_BYTES;
    localparam int C_IDX_W     = 3;

    // Wildcard characters.
    localparam logic [7:0] C_CHAR_STAR  = 8'h2A;
    localparam logic [7:0] C_CHAR_QMARK = 8'h3F;

    // Configuration register indexes.
    localparam logic [C_IDX_W-1:0] C_REG_WORD0 = 3'd0;
    localparam logic [C_IDX_W-1:0] C_REG_WORD1 = 3'd1;
    localparam logic [C_IDX_W-1:0] C_REG_WORD2 = 3'd2;
    localparam logic [C_IDX_W-1:0] C_REG_WORD3 = 3'd3;
    localparam logic [C_IDX_W-1:0] C_REG_LEN   = 3'd4;

    // Decoded pattern handed from the register block to the step logic.
    typedef struct packed {
        logic [C_PAT_BYTES-1:0][7:0] pat;
        logic [C_PAT_BYTES-1:0]      star;
        logic [C_PAT_BYTES-1:0]      qmark;
        logic [C_ACT_W-1:0]          len_mask;
        logic [C_ACT_W-1:0]          end_bit;
        logic [C_ACT_W-1:0]          start;
        logic                        glob;
        logic                        zero_len;
    } t_pat_info;

    // Star closure as a parallel prefix: bit i pulls in bit i-1 when
    // prop[i] is set, over runs of any length in log2 levels.
    function automatic logic [C_ACT_W-1:0] f_star_close(
        input logic [C_ACT_W-1:0] gen_in,
        input logic [C_ACT_W-1:0] prop_in
    );
        logic [C_ACT_W-1:0] g;
        logic [C_ACT_W-1:0] pp;
        g  = gen_in;
        pp = prop_in;
        for (int d = 1; d < C_ACT_W; d = d * 2) begin
            g  = g | (pp & (g << d));
            pp = pp & (pp << d);
        end
        return g;
    endfunction

endpackage

// ----- src/fgsm_cfg.sv -----
// Pattern registers and the decode of the pattern into masks for the step logic.
module fgsm_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr,
    input  logic [fgsm_pkg::C_IDX_W-1:0]  i_cfg_index,
    input  logic [fgsm_pkg::C_WORD_W-1:0] i_cfg_data,
    output fgsm_pkg::t_pat_info           o_info
);

    logic [fgsm_pkg::C_WORDS-1:0][fgsm_pkg::C_WORD_W-1:0] r_word;
    logic [fgsm_pkg::C_LEN_W-1:0]                         r_len;
    logic [fgsm_pkg::C_PAT_BYTES-1:0][7:0]                pat;
    logic [fgsm_pkg::C_LEN_W-1:0]                         len;
    logic [fgsm_pkg::C_PAT_BYTES-1:0]                     star;
    logic [fgsm_pkg::C_PAT_BYTES-1:0]                     qmark;
    logic [fgsm_pkg::C_ACT_W-1:0]                         len_mask;
    logic [fgsm_pkg::C_ACT_W-1:0]                         end_bit;
    logic [fgsm_pkg::C_PAT_BYTES-1:0]                     star_in;
    logic                                                 glob;

    // Register writes; indexes beyond the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word <= '0;
            r_len  <= '0;
        end else if (i_cfg_wr) begin
            unique case (i_cfg_index)
                fgsm_pkg::C_REG_WORD0: r_word[0] <= i_cfg_data;
                fgsm_pkg::C_REG_WORD1: r_word[1] <= i_cfg_data;
                fgsm_pkg::C_REG_WORD2: r_word[2] <= i_cfg_data;
                fgsm_pkg::C_REG_WORD3: r_word[3] <= i_cfg_data;
                fgsm_pkg::C_REG_LEN:   r_len <= i_cfg_data[fgsm_pkg::C_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // The words lay the pattern bytes out little-endian.
    assign pat = r_word;

    // A length beyond the pattern store counts as the full store.
    always_comb begin
        if (r_len > fgsm_pkg::C_LEN_W'(fgsm_pkg::C_PAT_BYTES)) begin
            len = fgsm_pkg::C_LEN_W'(fgsm_pkg::C_PAT_BYTES);
        end else begin
            len = r_len;
        end
    end

    // Per-position wildcard flags and length masks.
    always_comb begin
        for (int p = 0; p < fgsm_pkg::C_PAT_BYTES; p++) begin
            star[p]  = (pat[p] == fgsm_pkg::C_CHAR_STAR);
            qmark[p] = (pat[p] == fgsm_pkg::C_CHAR_QMARK);
        end
        for (int p = 0; p < fgsm_pkg::C_ACT_W; p++) begin
            len_mask[p] = (fgsm_pkg::C_LEN_W'(p) < len);
            end_bit[p]  = (fgsm_pkg::C_LEN_W'(p) == len);
        end
    end

    assign star_in = star & len_mask[fgsm_pkg::C_PAT_BYTES-1:0];
    assign glob    = |((star | qmark) & len_mask[fgsm_pkg::C_PAT_BYTES-1:0]);

    // Decoded pattern, including the set of positions at the start of a name.
    always_comb begin
        o_info.pat      = pat;
        o_info.star     = star;
        o_info.qmark    = qmark;
        o_info.len_mask = len_mask;
        o_info.end_bit  = end_bit;
        o_info.glob     = glob;
        o_info.zero_len = (len == '0);
        if (glob) begin
            o_info.start = fgsm_pkg::f_star_close(
                fgsm_pkg::C_ACT_W'(1), {star_in, 1'b0});
        end else begin
            o_info.start = fgsm_pkg::C_ACT_W'(1);
        end
    end

endmodule

// ----- src/fgsm_step.sv -----
// Next active-position set for one name byte, in glob or substring mode.
module fgsm_step (
    input  fgsm_pkg::t_pat_info          i_info,
    input  logic [fgsm_pkg::C_ACT_W-1:0] i_cur,
    input  logic [7:0]                   i_byte,
    output logic [fgsm_pkg::C_ACT_W-1:0] o_next,
    output logic                         o_hit
);

    logic [fgsm_pkg::C_PAT_BYTES-1:0] eq;
    logic [fgsm_pkg::C_PAT_BYTES-1:0] lm;
    logic [fgsm_pkg::C_PAT_BYTES-1:0] cur_lo;
    logic [fgsm_pkg::C_PAT_BYTES-1:0] star_in;
    logic [fgsm_pkg::C_PAT_BYTES-1:0] stay;
    logic [fgsm_pkg::C_PAT_BYTES-1:0] adv;
    logic [fgsm_pkg::C_ACT_W-1:0]     raw;

    // One comparator per pattern position.
    always_comb begin
        for (int p = 0; p < fgsm_pkg::C_PAT_BYTES; p++) begin
            eq[p] = (i_info.pat[p] == i_byte);
        end
    end

    assign lm      = i_info.len_mask[fgsm_pkg::C_PAT_BYTES-1:0];
    assign cur_lo  = i_cur[fgsm_pkg::C_PAT_BYTES-1:0];
    assign star_in = i_info.star & lm;

    // A star keeps its position; a question mark or equal byte moves one on.
    assign stay = cur_lo & star_in;
    assign adv  = cur_lo & (i_info.qmark | eq) & ~i_info.star & lm;
    assign raw  = {1'b0, stay} | {adv, 1'b0};

    // Glob mode closes over stars; substring mode restarts at every byte
    // and holds a completed match.
    always_comb begin
        if (i_info.glob) begin
            o_next = fgsm_pkg::f_star_close(raw, {star_in, 1'b0});
        end else begin
            o_next = fgsm_pkg::C_ACT_W'(1) | {cur_lo & eq & lm, 1'b0}
                   | (i_cur & i_info.end_bit);
        end
    end

    assign o_hit = |(o_next & i_info.end_bit);

endmodule

// ----- src/filename_glob_substring_match.sv -----
// Top level of the filename glob and substring matcher with its pipeline control.
// Takes one filename byte per cycle while the input is not stalled and gives one matched word at the name's last
// byte, or for an empty name.
// Each byte passes an input register, one pass of parallel compare and star-closure
// logic over all 33 pattern positions, and a result register; a stalled result
// holds only the input register while the set of positions waits. A pattern
// holding '*' or '?' must match the whole name; otherwise it matches as a
// substring. A write to one of the pattern registers restarts the name in
// progress, so writes should be made only while no name is being streamed; a
// write to an unused index is ignored.
module filename_glob_substring_match (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [7:0]                    i_name_byte,
    input  logic                          i_name_last,
    input  logic                          i_name_empty,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_matched,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [fgsm_pkg::C_IDX_W-1:0]  i_cfg_index,
    input  logic [fgsm_pkg::C_WORD_W-1:0] i_cfg_data
);

    fgsm_pkg::t_pat_info          info;
    logic                         cfg_wr;
    logic                         cfg_hit;
    logic                         r_in_valid;
    logic [7:0]                   r_in_byte;
    logic                         r_in_last;
    logic                         r_in_empty;
    logic                         r_out_valid;
    logic                         r_out_matched;
    logic                         r_restart;
    logic [fgsm_pkg::C_ACT_W-1:0] r_active;
    logic [fgsm_pkg::C_ACT_W-1:0] cur;
    logic [fgsm_pkg::C_ACT_W-1:0] nxt;
    logic                         hit;
    logic                         has_res;
    logic                         res_val;
    logic                         out_free;
    logic                         s1_go;
    logic                         in_take;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid & o_cfg_ready;

    // Only a write to an existing register restarts the name.
    assign cfg_hit     = cfg_wr & (i_cfg_index <= fgsm_pkg::C_REG_LEN);

    fgsm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr    (cfg_wr),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_info      (info)
    );

    // Current set of reachable positions.
    assign cur = r_restart ? info.start : r_active;

    fgsm_step u_step (
        .i_info (info),
        .i_cur  (cur),
        .i_byte (r_in_byte),
        .o_next (nxt),
        .o_hit  (hit)
    );

    // Result of the word in the input register.
    always_comb begin
        has_res = r_in_empty | r_in_last;
        if (r_in_empty || info.zero_len) begin
            res_val = info.zero_len;
        end else begin
            res_val = hit;
        end
    end

    // Handshake: the input register moves on when it carries no result or its result has a place to go.
    assign out_free   = ~r_out_valid | ~i_out_stall;
    assign s1_go      = r_in_valid & (~has_res | out_free);
    assign in_take    = ~r_in_valid | s1_go;
    assign o_in_stall = ~in_take;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take && i_in_valid) begin
            r_in_byte  <= i_name_byte;
            r_in_last  <= i_name_last;
            r_in_empty <= i_name_empty;
        end
    end

    // Position set; a register write, the end of a name or an empty pattern restarts it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_restart <= 1'b1;
        end else if (cfg_hit) begin
            r_restart <= 1'b1;
        end else if (s1_go) begin
            r_restart <= has_res | info.zero_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_active <= nxt;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && has_res) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && has_res) begin
            r_out_matched <= res_val;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_matched   = r_out_matched;

`ifndef NO_ASSERTIONS
    // A new result only comes from a word that ends or empties a name.
    a_res_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_in_valid && (r_in_last || r_in_empty)))
        else $error("result appeared without a closing word");

    // The input side stalls only while the input register holds a word.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid)
        else $error("input stalled with an empty input register");

    // A write to an existing register restarts the name in progress.
    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_hit |=> r_restart)
        else $error("register write did not restart the name");

    // A held result keeps its value while the sink stalls.
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_matched)))
        else $error("stalled result changed");
`endif

endmodule

// ----- tb/filename_glob_substring_match_checker.sv -----
`timescale 1ns / 100ps
// Checker that predicts the match result of every filename and compares it with the block's output.
module filename_glob_substring_match_checker
    import fgsm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  logic [7:0]          i_name_byte,
    input  logic                i_name_last,
    input  logic                i_name_empty,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  logic                i_matched,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic [C_IDX_W-1:0]  i_cfg_index,
    input  logic [C_WORD_W-1:0] i_cfg_data,
    output int                  o_fail_count,
    output int                  o_pending
);

    typedef logic [C_ACT_W-1:0] pos_set_t;

    // Shadow copy of the pattern registers and of the reachable pattern positions.
    logic [C_WORD_W-1:0] pat_word [C_WORDS];
    logic [C_LEN_W-1:0]  pat_len_reg;
    pos_set_t            positions;
    logic                expected_matches [$];

    // A length above the pattern capacity counts as the full capacity.
    function automatic int used_len();
        return (pat_len_reg > C_PAT_BYTES) ? C_PAT_BYTES : int'(pat_len_reg);
    endfunction

    function automatic logic [7:0] pat_char(int i);
        return pat_word[i / C_WORD_BYTES][8 * (i % C_WORD_BYTES) +: 8];
    endfunction

    // Any star or question mark in the used part switches to whole-name glob matching.
    function automatic logic is_glob(int n);
        logic g;
        g = 1'b0;
        for (int i = 0; i < n; i++) begin
            if (pat_char(i) == C_CHAR_STAR || pat_char(i) == C_CHAR_QMARK) g = 1'b1;
        end
        return g;
    endfunction

    // A reachable star also reaches the position after it, chained left to right.
    function automatic pos_set_t close_stars(pos_set_t s, int n);
        for (int p = 0; p < n; p++) begin
            if (s[p] && pat_char(p) == C_CHAR_STAR) s[p + 1] = 1'b1;
        end
        return s;
    endfunction

    function automatic pos_set_t start_positions();
        int n;
        n = used_len();
        if (is_glob(n)) return close_stars(pos_set_t'(1), n);
        return pos_set_t'(1);
    endfunction

    // Moves the reachable set over one name byte; n is nonzero here.
    function automatic pos_set_t advance_positions(pos_set_t s, logic [7:0] c, int n);
        pos_set_t nx;
        nx = '0;
        if (is_glob(n)) begin
            for (int p = 0; p < n; p++) begin
                if (s[p]) begin
                    if (pat_char(p) == C_CHAR_STAR) nx[p] = 1'b1;
                    else if (pat_char(p) == C_CHAR_QMARK || pat_char(p) == c) nx[p + 1] = 1'b1;
                end
            end
            return close_stars(nx, n);
        end
        // Substring search: a new match may start at every byte, and a full hit stays.
        nx[0] = 1'b1;
        for (int p = 0; p < n; p++) begin
            if (s[p] && pat_char(p) == c) nx[p + 1] = 1'b1;
        end
        nx[n] = nx[n] | s[n];
        return nx;
    endfunction

    always @(posedge i_clk) begin
        logic     want;
        int       n;
        pos_set_t nx;
        if (!i_rst_n) begin
            foreach (pat_word[w]) pat_word[w] = '0;
            pat_len_reg = '0;
            positions = start_positions();
            expected_matches.delete();
        end else begin
            // Check the result first; the pipeline latency keeps it apart from this edge's word.
            if (i_out_valid && !i_out_stall) begin
                if (expected_matches.size() == 0) begin
                    $error("matched: expected no result, actual %0b", i_matched);
                    o_fail_count++;
                end else begin
                    want = expected_matches.pop_front();
                    if (i_matched !== want) begin
                        $error("matched: expected %0b, actual %0b", want, i_matched);
                        o_fail_count++;
                    end
                end
            end

            // A write to a mapped register also restarts the name in progress.
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    C_REG_WORD0: pat_word[0] = i_cfg_data;
                    C_REG_WORD1: pat_word[1] = i_cfg_data;
                    C_REG_WORD2: pat_word[2] = i_cfg_data;
                    C_REG_WORD3: pat_word[3] = i_cfg_data;
                    C_REG_LEN:   pat_len_reg = i_cfg_data[C_LEN_W-1:0];
                    default: ;
                endcase
                if (i_cfg_index <= C_REG_LEN) positions = start_positions();
            end

            // Predict the result, if any, of the accepted name word.
            if (i_in_valid && !i_in_stall) begin
                n = used_len();
                if (i_name_empty) begin
                    expected_matches.push_back(n == 0);
                    positions = start_positions();
                end else if (n == 0) begin
                    positions = start_positions();
                    if (i_name_last) expected_matches.push_back(1'b1);
                end else begin
                    nx = advance_positions(positions, i_name_byte, n);
                    if (i_name_last) begin
                        expected_matches.push_back(nx[n]);
                        positions = start_positions();
                    end else begin
                        positions = nx;
                    end
                end
            end
        end
        o_pending = expected_matches.size();
    end

endmodule

// ----- tb/tb_filename_glob_substring_match.sv -----
`timescale 1ns / 100ps
// Testbench top that streams filenames and pattern writes into the matcher and gives the verdict.
module tb_filename_glob_substring_match;
    import fgsm_pkg::*;

    localparam int C_TARGET_WORDS = 1800;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [7:0]          name_byte;
    logic                name_last;
    logic                name_empty;
    logic                out_valid;
    logic                out_stall;
    logic                matched;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [C_IDX_W-1:0]  cfg_index;
    logic [C_WORD_W-1:0] cfg_data;
    int                  fail_count;
    int                  pending;

    // Stimulus state: current pattern, the name being built and the gap mode.
    logic                calm = 1'b0;
    int                  words_sent = 0;
    logic [7:0]          pat_bytes [C_PAT_BYTES];
    int                  pat_len;
    logic [7:0]          name_q [$];
    logic [C_IDX_W-1:0]  word_reg [C_WORDS] = '{C_REG_WORD0, C_REG_WORD1, C_REG_WORD2, C_REG_WORD3};

    filename_glob_substring_match DUT (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_name_byte  (name_byte),
        .i_name_last  (name_last),
        .i_name_empty (name_empty),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_matched    (matched),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    filename_glob_substring_match_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_name_byte  (name_byte),
        .i_name_last  (name_last),
        .i_name_empty (name_empty),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_matched    (matched),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #(5_000_000);
        $display("Simulation FAILED");
        $finish;
    end

    // The result side stalls for a drawn number of cycles before taking each word.
    initial begin
        int hold;
        out_stall = 1'b0;
        forever begin
            hold = calm ? 0 : $urandom_range(0, 11);
            @(negedge clk);
            out_stall <= (hold > 0);
            if (hold > 1) repeat (hold - 1) @(negedge clk);
            if (hold > 0) begin
                @(negedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!(out_valid && !out_stall));
        end
    end

    function automatic logic [7:0] pick_char();
        if ($urandom_range(0, 9) < 8) return 8'h61 + 8'($urandom_range(0, 2));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic int used_pat_len();
        return (pat_len > C_PAT_BYTES) ? C_PAT_BYTES : pat_len;
    endfunction

    // Drives one name word after a drawn gap and holds it until accepted.
    task automatic send_word(input logic [7:0] b, input logic last, input logic empty);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 11);
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        name_byte  <= b;
        name_last  <= last;
        name_empty <= empty;
        do @(posedge clk); while (in_stall);
        words_sent++;
    endtask

    // Waits until every expected result is in and the pipeline has drained.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [C_IDX_W-1:0] idx, input logic [C_WORD_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Writes all pattern registers in random order once the block is idle.
    task automatic load_pattern();
        logic [C_WORD_W-1:0] w [C_WORDS];
        int                  order [$];
        for (int i = 0; i < C_PAT_BYTES; i++) begin
            w[i / C_WORD_BYTES][8 * (i % C_WORD_BYTES) +: 8] = pat_bytes[i];
        end
        settle();
        // An unmapped index now and then; the block must ignore it.
        if ($urandom_range(0, 3) == 0) begin
            write_reg(C_IDX_W'($urandom_range(C_REG_LEN + 1, 2 ** C_IDX_W - 1)),
                      {$urandom, $urandom});
        end
        order = {0, 1, 2, 3, 4};
        order.shuffle();
        foreach (order[i]) begin
            if (order[i] == C_WORDS) begin
                write_reg(C_REG_LEN, ({$urandom, $urandom} & ~64'h3F) | C_WORD_W'(pat_len));
            end else begin
                write_reg(word_reg[order[i]], w[order[i]]);
            end
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Streams name_q; an empty queue goes out as an empty-name word.
    task automatic send_name(input bit noisy);
        if (name_q.size() == 0) begin
            send_word(8'($urandom), 1'($urandom), 1'b1);
        end else begin
            foreach (name_q[i]) begin
                // A stray empty-name word abandons the name so far.
                if (noisy && $urandom_range(0, 39) == 0) send_word(8'($urandom), 1'($urandom), 1'b1);
                send_word(name_q[i], i == name_q.size() - 1, 1'b0);
            end
        end
    endtask

    task automatic set_literal(input string s);
        foreach (pat_bytes[i]) pat_bytes[i] = 8'($urandom);
        for (int i = 0; i < s.len(); i++) pat_bytes[i] = s[i];
        pat_len = s.len();
        load_pattern();
    endtask

    task automatic send_text(input string s);
        name_q.delete();
        for (int i = 0; i < s.len(); i++) name_q.push_back(s[i]);
        send_name(1'b0);
    endtask

    // The first phases force the register extremes; the rest draw small patterns.
    task automatic make_pattern(input int phase);
        int  r;
        bit  glob;
        foreach (pat_bytes[i]) pat_bytes[i] = 8'($urandom);
        if (phase == 0) begin
            foreach (pat_bytes[i]) pat_bytes[i] = 8'hFF;
            pat_len = 63;
        end else if (phase == 1) begin
            foreach (pat_bytes[i]) pat_bytes[i] = 8'h00;
            pat_len = C_PAT_BYTES;
        end else begin
            r = $urandom_range(0, 19);
            if (r == 0) pat_len = 0;
            else if (r == 1) pat_len = $urandom_range(C_PAT_BYTES + 1, 63);
            else if (r <= 3) pat_len = $urandom_range(7, C_PAT_BYTES);
            else pat_len = $urandom_range(1, 6);
            glob = $urandom_range(0, 1);
            for (int i = 0; i < used_pat_len(); i++) begin
                r = $urandom_range(0, 9);
                if (glob && r < 2) pat_bytes[i] = C_CHAR_STAR;
                else if (glob && r < 3) pat_bytes[i] = C_CHAR_QMARK;
                else pat_bytes[i] = pick_char();
            end
        end
    endtask

    // Builds a name that mostly fits the pattern, then sometimes breaks it.
    task automatic build_name();
        int n;
        int r;
        int pos;
        bit wild;
        n = used_pat_len();
        wild = 1'b0;
        for (int i = 0; i < n; i++) begin
            if (pat_bytes[i] == C_CHAR_STAR || pat_bytes[i] == C_CHAR_QMARK) wild = 1'b1;
        end
        name_q.delete();
        r = $urandom_range(0, 9);
        if (r == 0) begin
            repeat ($urandom_range(1, 8)) name_q.push_back(8'($urandom));
        end else if (wild) begin
            for (int i = 0; i < n; i++) begin
                if (pat_bytes[i] == C_CHAR_STAR) repeat ($urandom_range(0, 3)) name_q.push_back(pick_char());
                else if (pat_bytes[i] == C_CHAR_QMARK) name_q.push_back(pick_char());
                else name_q.push_back(pat_bytes[i]);
            end
        end else begin
            repeat ($urandom_range(0, 4)) name_q.push_back(pick_char());
            if (r != 1) for (int i = 0; i < n; i++) name_q.push_back(pat_bytes[i]);
            repeat ($urandom_range(0, 4)) name_q.push_back(pick_char());
        end
        if ($urandom_range(0, 3) == 0 && name_q.size() > 0) begin
            pos = $urandom_range(0, name_q.size() - 1);
            case ($urandom_range(0, 2))
                0: name_q[pos] = pick_char();
                1: name_q.insert(pos, pick_char());
                default: name_q.delete(pos);
            endcase
        end
    endtask

    initial begin
        int phase;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        name_byte  = '0;
        name_last  = 1'b0;
        name_empty = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // Empty pattern after reset: an empty name and any name both match.
        send_word(8'hFF, 1'b1, 1'b1);
        name_q = {8'h00, 8'hFF};
        send_name(1'b0);

        // Plain substring, an empty name, and a name cut short by an empty-name word.
        set_literal("ab");
        send_text("xaby");
        send_word(8'h00, 1'b0, 1'b1);
        send_word("a", 1'b0, 1'b0);
        send_word(8'h55, 1'b0, 1'b1);
        send_word("b", 1'b1, 1'b0);

        // Glob with star and question mark must cover the whole name.
        set_literal("a*?");
        send_text("ab");
        send_text("a");
        send_word(8'h2A, 1'b1, 1'b1);

        set_literal("?");
        name_q = {8'hFF};
        send_name(1'b0);

        // A lone star still gives no match for an empty name.
        set_literal("*");
        send_word(8'h00, 1'b0, 1'b1);

        // Random phases: new pattern, then a batch of names.
        phase = 0;
        while (words_sent < C_TARGET_WORDS) begin
            make_pattern(phase);
            load_pattern();
            calm = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(8, 25)) begin
                build_name();
                send_name(1'b1);
            end
            calm = 1'b0;
            phase++;
        end

        settle();
        repeat (10) @(negedge clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/fgsm_pkg.sv
src/fgsm_cfg.sv
src/fgsm_step.sv
src/filename_glob_substring_match.sv
tb/filename_glob_substring_match_checker.sv
tb/tb_filename_glob_substring_match.sv
